// ===== hw/rtl/ray_unit_box_slab_test_unit_macros.svh =====
// Assertion macros shared by the ray and box slab test RTL.
`ifndef RAY_UNIT_BOX_SLAB_TEST_UNIT_MACROS_SVH
`define RAY_UNIT_BOX_SLAB_TEST_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RUSBT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rusbt assertion failed");

// Next-cycle implication, disabled during reset.
`define RUSBT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rusbt assertion failed");

`endif

// ===== hw/rtl/rusbt_pkg.sv =====
// Types, constants and helpers for the ray and box slab test.
`default_nettype none
package rusbt_pkg;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] hit_distance;
  } ray_out_t;

  // Flags that travel beside the quotient through the divider.
  typedef struct packed {
    logic ovf;
    logic neg;
    logic den_zero;
    logic num_zero;
    logic num_pos;
  } div_flags_t;

  localparam logic [2:0]  REG_MIN_DISTANCE = 3'd0;
  localparam logic [15:0] MIN_DISTANCE_RESET = 16'd66;
  localparam logic signed [33:0] ONE_Q16 = 34'sd65536;
  localparam logic signed [31:0] Q32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;
  localparam int DIV_STEPS = 32;
  // Divider latency: operand stage, one stage per quotient bit, result stage.
  localparam int DIV_LAT = DIV_STEPS + 2;

  // Slab plane numerator; the direction's sign picks the near plane.
  function automatic logic signed [33:0] slab_num(input logic signed [31:0] o,
                                                  input logic dneg,
                                                  input logic far_sel);
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    lo = -ONE_Q16 - 34'(o);
    hi = ONE_Q16 - 34'(o);
    return (dneg ^ far_sel) ? hi : lo;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rusbt_div.sv =====
// Pipelined saturating Q16.16 divider, one quotient bit per stage.
`default_nettype none
module rusbt_div import rusbt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [33:0] num,
  input  wire logic signed [31:0] den,
  output logic signed [31:0]      quo
);

  logic [63:0]  w_s   [0:DIV_STEPS];
  logic [31:0]  b_s   [0:DIV_STEPS];
  div_flags_t   f_s   [0:DIV_STEPS];

  logic [32:0]  a_mag;
  logic [31:0]  b_mag;
  div_flags_t   f_pre;

  function automatic logic [63:0] div_step(input logic [63:0] w, input logic [31:0] b);
    logic [32:0] cand;
    logic [32:0] diff;
    cand = w[63:31];
    diff = cand - {1'b0, b};
    if (cand >= {1'b0, b}) begin
      return {diff[31:0], w[30:0], 1'b1};
    end
    return {cand[31:0], w[30:0], 1'b0};
  endfunction

  always_comb begin
    a_mag = num[33] ? 33'(-num) : num[32:0];
    b_mag = den[31] ? 32'(-den) : den;
    // The quotient needs more than 32 bits when |num| / 2^16 >= |den|.
    f_pre.ovf      = {15'd0, a_mag[32:16]} >= b_mag;
    f_pre.neg      = num[33] ^ den[31];
    f_pre.den_zero = (den == 32'sd0);
    f_pre.num_zero = (num == 34'sd0);
    f_pre.num_pos  = !num[33];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_s[0] <= {15'd0, a_mag[32:16], a_mag[15:0], 16'd0};
      b_s[0] <= b_mag;
      f_s[0] <= f_pre;
      for (int i = 0; i < DIV_STEPS; i++) begin
        w_s[i+1] <= div_step(w_s[i], b_s[i]);
        b_s[i+1] <= b_s[i];
        f_s[i+1] <= f_s[i];
      end
    end
  end

  logic [31:0] q;
  div_flags_t  fl;
  assign q  = w_s[DIV_STEPS][31:0];
  assign fl = f_s[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl.den_zero) begin
        quo <= fl.num_zero ? 32'sd0 : (fl.num_pos ? Q32_MAX : Q32_MIN);
      end else if (fl.neg) begin
        quo <= (fl.ovf || q[31]) ? Q32_MIN : 32'(-q);
      end else begin
        quo <= (fl.ovf || q[31]) ? Q32_MAX : q;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rusbt_merge.sv =====
// Interval narrowing over the three axes and the final hit decision.
`default_nettype none
module rusbt_merge import rusbt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_v,
  input  wire logic signed [31:0] x0,
  input  wire logic signed [31:0] x1,
  input  wire logic signed [31:0] y0,
  input  wire logic signed [31:0] y1,
  input  wire logic signed [31:0] z0,
  input  wire logic signed [31:0] z1,
  input  wire logic [15:0]        min_distance,
  output logic                    out_v,
  output ray_out_t                out_word
);

  logic               v1;
  logic               miss1;
  logic signed [31:0] t0;
  logic signed [31:0] t1;
  logic signed [31:0] zn;
  logic signed [31:0] zf;

  logic               miss2;
  logic signed [31:0] tf;
  logic               hit_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      out_v <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss1 <= (x0 > y1) || (y0 > x1);
      t0    <= (y0 > x0) ? y0 : x0;
      t1    <= (y1 < x1) ? y1 : x1;
      zn    <= z0;
      zf    <= z1;
    end
  end

  always_comb begin
    miss2 = miss1 || (t0 > zf) || (zn > t1);
    tf    = (zn > t0) ? zn : t0;
    hit_c = !miss2 && (tf > $signed({16'd0, min_distance}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.hit          <= hit_c;
      out_word.hit_distance <= hit_c ? tf[30:0] : 31'd0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ray_unit_box_slab_test_unit.sv =====
// Top level of the ray against unit box slab test.
//
// Input channel in_valid/in_ready/in_data carries one ray word: origin and
// direction, signed Q16.16, already in object space. Output channel
// out_valid/out_ready/out_data returns one word per ray: hit and the entry
// distance (zero on a miss). Words leave in the order they arrive.
// From the accepting edge, where the input register loads, a ray passes
// through the six parallel dividers (one quotient bit per stage) and the
// interval merge registers before out_valid rises. One ray per cycle is
// accepted while out_ready does not freeze the pipeline.
// When the receiver holds out_ready low with a word waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and sets min_distance to 66.
// The APB port holds min_distance at offset 0; write it only while the
// pipeline is empty.
`default_nettype none
module ray_unit_box_slab_test_unit import rusbt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire ray_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output ray_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  `include "ray_unit_box_slab_test_unit_macros.svh"

  logic               adv;
  logic [15:0]        min_distance;
  logic               v_in;
  ray_in_t            ray;
  logic [DIV_LAT-1:0] v_pipe;

  logic signed [31:0] o_ax [0:2];
  logic signed [31:0] d_ax [0:2];
  logic signed [31:0] t_near [0:2];
  logic signed [31:0] t_far  [0:2];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= MIN_DISTANCE_RESET;
    end else if (psel && penable && pwrite && paddr == REG_MIN_DISTANCE) begin
      min_distance <= pwdata[15:0];
    end
  end

  assign prdata = (paddr == REG_MIN_DISTANCE) ? {16'd0, min_distance} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in   <= 1'b0;
      v_pipe <= '0;
    end else if (adv) begin
      v_in   <= in_valid;
      v_pipe <= {v_pipe[DIV_LAT-2:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray <= in_data;
    end
  end

  assign o_ax[0] = ray.origin_x;
  assign o_ax[1] = ray.origin_y;
  assign o_ax[2] = ray.origin_z;
  assign d_ax[0] = ray.dir_x;
  assign d_ax[1] = ray.dir_y;
  assign d_ax[2] = ray.dir_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rusbt_div u_near (
      .clk (clk),
      .en  (adv),
      .num (slab_num(o_ax[a], d_ax[a][31], 1'b0)),
      .den (d_ax[a]),
      .quo (t_near[a])
    );
    rusbt_div u_far (
      .clk (clk),
      .en  (adv),
      .num (slab_num(o_ax[a], d_ax[a][31], 1'b1)),
      .den (d_ax[a]),
      .quo (t_far[a])
    );
  end

  rusbt_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_v         (v_pipe[DIV_LAT-1]),
    .x0           (t_near[0]),
    .x1           (t_far[0]),
    .y0           (t_near[1]),
    .y1           (t_far[1]),
    .z0           (t_near[2]),
    .z1           (t_far[2]),
    .min_distance (min_distance),
    .out_v        (out_valid),
    .out_word     (out_data)
  );

  `RUSBT_ASSERT_IMP(a_miss_zero, clk, rst, out_valid && !out_data.hit, out_data.hit_distance == 31'd0)
  `RUSBT_ASSERT_IMP(a_hit_beyond_min, clk, rst, out_valid && out_data.hit, out_data.hit_distance > {15'd0, min_distance})
  `RUSBT_ASSERT_NXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule
`default_nettype wire

// ===== dv/ray_unit_box_slab_test_unit_tb.sv =====
// Self-checking testbench for the ray against unit box slab test unit.
`timescale 1ns / 100ps
`default_nettype none
module ray_unit_box_slab_test_unit_tb;
  import rusbt_pkg::*;

  // Predicts the hit word of each accepted ray and checks the returned words in order.
  class slab_hit_board;
    ray_out_t   pending_hits[$];
    logic [15:0] min_dist;
    int         mismatches;

    function new();
      min_dist   = MIN_DISTANCE_RESET;
      mismatches = 0;
    endfunction

    // Slab distance: numerator * 2^16 / divisor, truncated toward zero, saturated.
    function automatic longint plane_dist(longint num, longint den);
      longint q;
      if (den == 0) begin
        if (num > 0) return 64'sd2147483647;
        if (num < 0) return -64'sd2147483648;
        return 0;
      end
      q = (num * 65536) / den;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function automatic void axis_span(longint o, longint d, output longint t_near,
                                      output longint t_far);
      longint lo;
      longint hi;
      lo = -65536 - o;
      hi = 65536 - o;
      if (d >= 0) begin
        t_near = plane_dist(lo, d);
        t_far  = plane_dist(hi, d);
      end else begin
        t_near = plane_dist(hi, d);
        t_far  = plane_dist(lo, d);
      end
    endfunction

    function void note_ray(ray_in_t r);
      longint t0, t1, a0, a1;
      ray_out_t res;
      bit hit;
      res = '0;
      hit = 1'b1;
      axis_span(longint'(r.origin_x), longint'(r.dir_x), t0, t1);
      axis_span(longint'(r.origin_y), longint'(r.dir_y), a0, a1);
      if (t0 > a1 || a0 > t1) hit = 1'b0;
      if (a0 > t0) t0 = a0;
      if (a1 < t1) t1 = a1;
      if (hit) begin
        axis_span(longint'(r.origin_z), longint'(r.dir_z), a0, a1);
        if (t0 > a1 || a0 > t1) hit = 1'b0;
        if (a0 > t0) t0 = a0;
      end
      if (hit && t0 > longint'(min_dist)) begin
        res.hit          = 1'b1;
        res.hit_distance = t0[30:0];
      end
      pending_hits.push_back(res);
    endfunction

    function void check_word(ray_out_t got);
      ray_out_t exp_w;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", got);
        return;
      end
      exp_w = pending_hits.pop_front();
      if (got.hit !== exp_w.hit || got.hit_distance !== exp_w.hit_distance) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected hit=%0b dist=%h, got hit=%0b dist=%h",
                   exp_w.hit, exp_w.hit_distance, got.hit, got.hit_distance);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  ray_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  ray_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  slab_hit_board board;
  bit          calm_tail;
  bit          long_hold;

  ray_unit_box_slab_test_unit i_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("ray_unit_box_slab_test_unit regression: fail");
    $finish;
  end

  // Receiver: random stall bursts, one long hold on request, none at the tail.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_word(out_data);
  end

  task automatic write_min_dist(logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MIN_DISTANCE;
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.min_dist = val;
  endtask

  task automatic send_ray(ray_in_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk iff in_ready);
    board.note_ray(r);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending_hits.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 6 * 65536)) - 3 * 65536);
      2: return $urandom_range(0, 1) ? 32'sh0001_0000 : 32'shFFFF_0000;
      3: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
    endcase
  endfunction

  function automatic logic [31:0] pick_dir();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
    endcase
  endfunction

  // Aims the ray close to a random point in the cube from -4 to +4 on each axis.
  function automatic ray_in_t aimed_ray();
    ray_in_t r;
    logic signed [31:0] tgt;
    r.origin_x = pick_coord();
    r.origin_y = pick_coord();
    r.origin_z = pick_coord();
    tgt = 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
    r.dir_x = 32'(tgt - (r.origin_x >>> 2));
    tgt = 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
    r.dir_y = 32'(tgt - (r.origin_y >>> 2));
    tgt = 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
    r.dir_z = 32'(tgt - (r.origin_z >>> 2));
    return r;
  endfunction

  function automatic ray_in_t random_ray();
    ray_in_t r;
    if ($urandom_range(0, 9) < 6) return aimed_ray();
    r.origin_x = pick_coord();
    r.origin_y = pick_coord();
    r.origin_z = pick_coord();
    r.dir_x    = pick_dir();
    r.dir_y    = pick_dir();
    r.dir_z    = pick_dir();
    return r;
  endfunction

  task automatic random_phase(int count, bit idle);
    for (int i = 0; i < count; i++) begin
      if (idle && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      send_ray(random_ray());
    end
    drop_valid();
  endtask

  initial begin
    ray_in_t r;
    logic [15:0] dist_set[4];
    board     = new();
    calm_tail = 1'b0;
    long_hold = 1'b0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rays at reset minimum distance.
    r = '{32'shFFFD_0000, 0, 0, 32'sh0001_0000, 0, 0};         // hit along +x
    send_ray(r);
    r = '{32'sh0003_0000, 0, 0, 32'shFFFF_0000, 0, 0};         // hit along -x
    send_ray(r);
    r = '{0, 0, 0, 32'sh0001_0000, 32'sh0000_8000, 0};         // starts inside
    send_ray(r);
    r = '{0, 0, 0, 0, 0, 0};                                   // all-zero direction
    send_ray(r);
    r = '{32'sh0005_0000, 32'sh0005_0000, 0, 0, 0, 32'sh0001_0000};   // zero dir, outside
    send_ray(r);
    r = '{32'sh0001_0000, 0, 32'shFFFC_0000, 0, 0, 32'sh0001_0000};   // zero numerator
    send_ray(r);
    r = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001};             // huge quotient
    send_ray(r);
    r = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    send_ray(r);
    r = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF,
          32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'sh8000_0000};
    send_ray(r);
    r = '{32'shFFFE_0000, 32'shFFFE_0000, 32'shFFFE_0000,
          32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000};             // corner diagonal
    send_ray(r);
    r = '{32'shFFFE_0000, 32'sh0003_0000, 0, 32'sh0001_0000, 0, 0};   // parallel miss
    send_ray(r);
    r = '{32'shFFFE_FFBE, 0, 0, 32'sh0001_0000, 0, 0};                // entry equals minimum
    send_ray(r);
    r = '{32'shFFFE_FFBD, 0, 0, 32'sh0001_0000, 0, 0};                // just beyond minimum
    send_ray(r);
    drop_valid();
    drain();

    // Several minimum distances, the extremes among them.
    dist_set = '{16'd0, 16'hFFFF, 16'd66, 16'd0};
    for (int k = 0; k < 4; k++) begin
      write_min_dist(k == 3 ? 16'($urandom_range(0, 16'hFFFF)) : dist_set[k]);
      r = '{32'shFFFF_0000, 0, 0, 32'sh0001_0000, 0, 0};              // entry exactly zero
      send_ray(r);
      r = '{32'shFFFE_0000, 0, 0, 32'sh0001_0000, 0, 0};              // entry exactly one
      send_ray(r);
      random_phase(210, 1'b1);
      drain();
    end

    // Back pressure: the receiver holds off while rays keep coming.
    long_hold = 1'b1;
    random_phase(150, 1'b0);
    drain();

    // Sender pauses until every word is back, then carries on.
    random_phase(100, 1'b1);
    drain();
    write_min_dist(16'($urandom_range(0, 300)));
    random_phase(150, 1'b1);
    drain();

    calm_tail = 1'b1;
    random_phase(100, 1'b0);
    drain();
    repeat (40) @(posedge clk);

    if (board.mismatches == 0 && board.pending_hits.size() == 0)
      $display("ray_unit_box_slab_test_unit regression: pass");
    else
      $display("ray_unit_box_slab_test_unit regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rusbt_pkg.sv
hw/rtl/rusbt_div.sv
hw/rtl/rusbt_merge.sv
hw/rtl/ray_unit_box_slab_test_unit.sv
dv/ray_unit_box_slab_test_unit_tb.sv
